// File: rtl/rpn_pkg.sv
package rpn_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned DepthW = 8;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned StW    = 3;
  localparam int unsigned UpcW   = 5;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH    = 3'd0,
    REQ_ADD     = 3'd1,
    REQ_SUB     = 3'd2,
    REQ_MUL     = 3'd3,
    REQ_DIV     = 3'd4,
    REQ_EOL     = 3'd5,
    REQ_INVALID = 3'd6
  } req_e;

  typedef enum logic [StW-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_FEW     = 3'd2,
    ST_DIVZ    = 3'd3,
    ST_INVALID = 3'd4,
    ST_RESULT  = 3'd5,
    ST_MANY    = 3'd6,
    ST_EMPTY   = 3'd7
  } st_e;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_LATCH,
    UOP_PUSH,
    UOP_READ_A,
    UOP_ADD,
    UOP_SUB,
    UOP_MUL_P,
    UOP_MUL_R,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_DIV_FIN,
    UOP_DIVZ,
    UOP_EMIT
  } uop_e;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_IN_ACC,
    C_OUT_FREE,
    C_FULL,
    C_FEW,
    C_BZERO,
    C_SP0,
    C_SP1,
    C_DIV_BUSY,
    C_DISPATCH,
    C_OPSEL
  } cond_e;

  typedef logic [UpcW-1:0] upc_t;

  localparam upc_t U_IDLE      = 5'd0;
  localparam upc_t U_DISP      = 5'd1;
  localparam upc_t U_PUSH_CHK  = 5'd2;
  localparam upc_t U_PUSH      = 5'd3;
  localparam upc_t U_OP_CHK    = 5'd4;
  localparam upc_t U_RD_A      = 5'd5;
  localparam upc_t U_ADD       = 5'd6;
  localparam upc_t U_SUB       = 5'd7;
  localparam upc_t U_MUL_P     = 5'd8;
  localparam upc_t U_MUL_R     = 5'd9;
  localparam upc_t U_DIV_CHK   = 5'd10;
  localparam upc_t U_DIV_INIT  = 5'd11;
  localparam upc_t U_DIV_STEP  = 5'd12;
  localparam upc_t U_DIV_FIN   = 5'd13;
  localparam upc_t U_DIVZ      = 5'd14;
  localparam upc_t U_EOL_CHK1  = 5'd15;
  localparam upc_t U_EOL_CHK0  = 5'd16;
  localparam upc_t U_E_MANY    = 5'd17;
  localparam upc_t U_E_OK      = 5'd18;
  localparam upc_t U_E_FULL    = 5'd19;
  localparam upc_t U_E_FEW     = 5'd20;
  localparam upc_t U_E_DIVZ    = 5'd21;
  localparam upc_t U_E_INV     = 5'd22;
  localparam upc_t U_E_RES     = 5'd23;
  localparam upc_t U_E_EMPTY   = 5'd24;

  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    upc_t  target;
    logic  hold;
    st_e   status;
    logic  vsel_top;
    logic  clr_sp;
  } ctrl_t;

  typedef struct packed {
    logic [ReqW-1:0] req;
    logic            in_acc;
    logic            out_free;
    logic            full;
    logic            few;
    logic            bzero;
    logic            sp0;
    logic            sp1;
    logic            div_busy;
  } flags_t;

  function automatic ctrl_t cw(uop_e u, cond_e c, upc_t t, logic h);
    ctrl_t w;
    w.uop      = u;
    w.cond     = c;
    w.target   = t;
    w.hold     = h;
    w.status   = ST_OK;
    w.vsel_top = 1'b1;
    w.clr_sp   = 1'b0;
    return w;
  endfunction

  // result step: waits for a free output slot, then back to idle
  function automatic ctrl_t ew(st_e s, logic vtop, logic clr);
    ctrl_t w;
    w          = cw(UOP_EMIT, C_OUT_FREE, U_IDLE, 1'b1);
    w.status   = s;
    w.vsel_top = vtop;
    w.clr_sp   = clr;
    return w;
  endfunction

  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t w;
    case (pc)
      U_IDLE:     w = cw(UOP_LATCH,    C_IN_ACC,   U_DISP,     1'b1);
      U_DISP:     w = cw(UOP_NOP,      C_DISPATCH, U_IDLE,     1'b0);
      U_PUSH_CHK: w = cw(UOP_NOP,      C_FULL,     U_E_FULL,   1'b0);
      U_PUSH:     w = cw(UOP_PUSH,     C_ALWAYS,   U_E_OK,     1'b0);
      U_OP_CHK:   w = cw(UOP_NOP,      C_FEW,      U_E_FEW,    1'b0);
      U_RD_A:     w = cw(UOP_READ_A,   C_OPSEL,    U_IDLE,     1'b0);
      U_ADD:      w = cw(UOP_ADD,      C_ALWAYS,   U_E_OK,     1'b0);
      U_SUB:      w = cw(UOP_SUB,      C_ALWAYS,   U_E_OK,     1'b0);
      U_MUL_P:    w = cw(UOP_MUL_P,    C_NONE,     U_IDLE,     1'b0);
      U_MUL_R:    w = cw(UOP_MUL_R,    C_ALWAYS,   U_E_OK,     1'b0);
      U_DIV_CHK:  w = cw(UOP_NOP,      C_BZERO,    U_DIVZ,     1'b0);
      U_DIV_INIT: w = cw(UOP_DIV_INIT, C_NONE,     U_IDLE,     1'b0);
      U_DIV_STEP: w = cw(UOP_DIV_STEP, C_DIV_BUSY, U_DIV_STEP, 1'b0);
      U_DIV_FIN:  w = cw(UOP_DIV_FIN,  C_ALWAYS,   U_E_OK,     1'b0);
      U_DIVZ:     w = cw(UOP_DIVZ,     C_ALWAYS,   U_E_DIVZ,   1'b0);
      U_EOL_CHK1: w = cw(UOP_NOP,      C_SP1,      U_E_RES,    1'b0);
      U_EOL_CHK0: w = cw(UOP_NOP,      C_SP0,      U_E_EMPTY,  1'b0);
      U_E_MANY:   w = ew(ST_MANY,    1'b0, 1'b1);
      U_E_OK:     w = ew(ST_OK,      1'b1, 1'b0);
      U_E_FULL:   w = ew(ST_FULL,    1'b1, 1'b0);
      U_E_FEW:    w = ew(ST_FEW,     1'b1, 1'b0);
      U_E_DIVZ:   w = ew(ST_DIVZ,    1'b1, 1'b0);
      U_E_INV:    w = ew(ST_INVALID, 1'b1, 1'b0);
      U_E_RES:    w = ew(ST_RESULT,  1'b1, 1'b1);
      U_E_EMPTY:  w = ew(ST_EMPTY,   1'b0, 1'b1);
      default:    w = cw(UOP_NOP,      C_ALWAYS,   U_IDLE,     1'b0);
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(logic [ReqW-1:0] req);
    upc_t t;
    case (req)
      REQ_PUSH:                         t = U_PUSH_CHK;
      REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: t = U_OP_CHK;
      REQ_EOL:                          t = U_EOL_CHK1;
      default:                          t = U_E_INV;
    endcase
    return t;
  endfunction

  function automatic upc_t opsel(logic [ReqW-1:0] req);
    upc_t t;
    case (req)
      REQ_ADD: t = U_ADD;
      REQ_SUB: t = U_SUB;
      REQ_MUL: t = U_MUL_P;
      default: t = U_DIV_CHK;
    endcase
    return t;
  endfunction

  // sign/magnitude to saturated two's complement; big = magnitude above 32 bits
  function automatic logic [DataW-1:0] sat_mag(logic neg, logic big, logic [DataW-1:0] m);
    logic over;
    logic [DataW-1:0] r;
    over = big | m[DataW-1];
    if (neg) begin
      r = over ? {1'b1, {(DataW-1){1'b0}}} : (~m + 1'b1);
    end else begin
      r = over ? {1'b0, {(DataW-1){1'b1}}} : m;
    end
    return r;
  endfunction

  function automatic logic [DataW-1:0] sat_addsub(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                                  logic sub);
    logic [DataW:0] bx;
    logic [DataW:0] s;
    logic [DataW-1:0] r;
    bx = {b[DataW-1], b};
    if (sub) begin
      bx = ~bx + 1'b1;
    end
    s = {a[DataW-1], a} + bx;
    if (s[DataW] != s[DataW-1]) begin
      r = s[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      r = s[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/rpn_ram.sv
module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rpn_seq.sv
module rpn_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rpn_pkg::flags_t flags_i,
  output rpn_pkg::ctrl_t  ctrl_o
);

  rpn_pkg::upc_t  upc_q, upc_d;
  rpn_pkg::ctrl_t ctrl;
  rpn_pkg::upc_t  tgt;
  logic           taken;

  always_comb begin
    ctrl = rpn_pkg::ucode(upc_q);
  end

  always_comb begin
    tgt   = ctrl.target;
    taken = 1'b0;
    case (ctrl.cond)
      rpn_pkg::C_NONE:     taken = 1'b0;
      rpn_pkg::C_ALWAYS:   taken = 1'b1;
      rpn_pkg::C_IN_ACC:   taken = flags_i.in_acc;
      rpn_pkg::C_OUT_FREE: taken = flags_i.out_free;
      rpn_pkg::C_FULL:     taken = flags_i.full;
      rpn_pkg::C_FEW:      taken = flags_i.few;
      rpn_pkg::C_BZERO:    taken = flags_i.bzero;
      rpn_pkg::C_SP0:      taken = flags_i.sp0;
      rpn_pkg::C_SP1:      taken = flags_i.sp1;
      rpn_pkg::C_DIV_BUSY: taken = flags_i.div_busy;
      rpn_pkg::C_DISPATCH: begin
        taken = 1'b1;
        tgt   = rpn_pkg::dispatch(flags_i.req);
      end
      rpn_pkg::C_OPSEL: begin
        taken = 1'b1;
        tgt   = rpn_pkg::opsel(flags_i.req);
      end
      default:             taken = 1'b0;
    endcase
    if (taken) begin
      upc_d = tgt;
    end else if (ctrl.hold) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= rpn_pkg::U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

// File: rtl/rpn_dp.sv
module rpn_dp #(
  parameter int unsigned STACK_DEPTH = 128,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rpn_pkg::ctrl_t                       ctrl_i,
  output rpn_pkg::flags_t                      flags_o,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [rpn_pkg::ReqW-1:0]             in_req_i,
  input  logic [rpn_pkg::DataW-1:0]            in_num_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [rpn_pkg::StW-1:0]              out_status_o,
  output logic [rpn_pkg::DataW-1:0]            out_value_o,
  output logic [rpn_pkg::DepthW-1:0]           out_depth_o
);

  localparam int unsigned DW  = rpn_pkg::DataW;
  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned QW  = DW + FRAC_BITS;
  localparam int unsigned CW  = $clog2(QW);

  logic [rpn_pkg::ReqW-1:0] req_q, req_d;
  logic [DW-1:0]            num_q, num_d;
  logic [DW-1:0]            top_q, top_d;
  logic [SPW-1:0]           sp_q, sp_d;
  logic [2*DW-1:0]          prod_q, prod_d;
  logic                     neg_q, neg_d;
  logic [QW-1:0]            dvd_q, dvd_d;
  logic [DW-1:0]            dvs_q, dvs_d;
  logic [DW-1:0]            rem_q, rem_d;
  logic [DW-1:0]            quo_q, quo_d;
  logic                     ovf_q, ovf_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     ov_q, ov_d;
  logic [rpn_pkg::StW-1:0]  os_q, os_d;
  logic [DW-1:0]            ov_val_q, ov_val_d;
  logic [rpn_pkg::DepthW-1:0] od_q, od_d;

  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [DW-1:0]            a_val;
  logic [DW-1:0]            abs_a, abs_b;
  logic [2*DW-1:0]          mul_full, mul_m;
  logic [DW:0]              rem2, diff;
  logic                     ge;
  logic [DW-1:0]            top_val;
  logic                     in_acc, out_free, fire;
  logic [SPW-1:0]           sp_m1, sp_m2;

  rpn_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (top_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (a_val)
  );

  // top of stack lives in top_q; entries below it live in the RAM
  assign sp_m1     = sp_q - 1'b1;
  assign sp_m2     = sp_q - 2'd2;
  assign mem_waddr = sp_m1[AW-1:0];
  assign mem_raddr = sp_m2[AW-1:0];
  assign mem_we    = (ctrl_i.uop == rpn_pkg::UOP_PUSH) && (sp_q != '0);
  assign mem_re    = (ctrl_i.uop == rpn_pkg::UOP_READ_A);

  assign in_ready_o = (ctrl_i.uop == rpn_pkg::UOP_LATCH);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !ov_q || out_ready_i;
  assign fire       = (ctrl_i.uop == rpn_pkg::UOP_EMIT) && out_free;

  assign abs_a    = a_val[DW-1] ? (~a_val + 1'b1) : a_val;
  assign abs_b    = top_q[DW-1] ? (~top_q + 1'b1) : top_q;
  assign mul_full = {{DW{1'b0}}, abs_a} * {{DW{1'b0}}, abs_b};
  assign mul_m    = prod_q >> FRAC_BITS;
  assign rem2     = {rem_q, dvd_q[QW-1]};
  assign diff     = rem2 - {1'b0, dvs_q};
  assign ge       = !diff[DW];
  assign top_val  = (sp_q == '0) ? '0 : top_q;

  always_comb begin
    req_d    = req_q;
    num_d    = num_q;
    top_d    = top_q;
    sp_d     = sp_q;
    prod_d   = prod_q;
    neg_d    = neg_q;
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    ovf_d    = ovf_q;
    cnt_d    = cnt_q;
    os_d     = os_q;
    ov_val_d = ov_val_q;
    od_d     = od_q;
    ov_d     = out_ready_i ? 1'b0 : ov_q;
    case (ctrl_i.uop)
      rpn_pkg::UOP_LATCH: begin
        if (in_acc) begin
          req_d = in_req_i;
          num_d = in_num_i;
        end
      end
      rpn_pkg::UOP_PUSH: begin
        top_d = num_q;
        sp_d  = sp_q + 1'b1;
      end
      rpn_pkg::UOP_ADD: begin
        top_d = rpn_pkg::sat_addsub(a_val, top_q, 1'b0);
        sp_d  = sp_m1;
      end
      rpn_pkg::UOP_SUB: begin
        top_d = rpn_pkg::sat_addsub(a_val, top_q, 1'b1);
        sp_d  = sp_m1;
      end
      rpn_pkg::UOP_MUL_P: begin
        prod_d = mul_full;
        neg_d  = a_val[DW-1] ^ top_q[DW-1];
      end
      rpn_pkg::UOP_MUL_R: begin
        top_d = rpn_pkg::sat_mag(neg_q, |mul_m[2*DW-1:DW], mul_m[DW-1:0]);
        sp_d  = sp_m1;
      end
      rpn_pkg::UOP_DIV_INIT: begin
        dvd_d = QW'(abs_a) << FRAC_BITS;
        dvs_d = abs_b;
        rem_d = '0;
        quo_d = '0;
        ovf_d = 1'b0;
        cnt_d = CW'(QW - 1);
        neg_d = a_val[DW-1] ^ top_q[DW-1];
      end
      rpn_pkg::UOP_DIV_STEP: begin
        rem_d = ge ? diff[DW-1:0] : rem2[DW-1:0];
        quo_d = {quo_q[DW-2:0], ge};
        ovf_d = ovf_q | quo_q[DW-1];
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q - 1'b1;
      end
      rpn_pkg::UOP_DIV_FIN: begin
        top_d = rpn_pkg::sat_mag(neg_q, ovf_q, quo_q);
        sp_d  = sp_m1;
      end
      rpn_pkg::UOP_DIVZ: begin
        top_d = a_val;
        sp_d  = sp_m1;
      end
      rpn_pkg::UOP_EMIT: begin
        if (fire) begin
          ov_d     = 1'b1;
          os_d     = ctrl_i.status;
          ov_val_d = ctrl_i.vsel_top ? top_val : '0;
          od_d     = ctrl_i.clr_sp ? '0 : rpn_pkg::DepthW'(sp_q);
          if (ctrl_i.clr_sp) begin
            sp_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      ov_q <= 1'b0;
    end else begin
      sp_q <= sp_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    num_q    <= num_d;
    top_q    <= top_d;
    prod_q   <= prod_d;
    neg_q    <= neg_d;
    dvd_q    <= dvd_d;
    dvs_q    <= dvs_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    ovf_q    <= ovf_d;
    cnt_q    <= cnt_d;
    os_q     <= os_d;
    ov_val_q <= ov_val_d;
    od_q     <= od_d;
  end

  always_comb begin
    flags_o.req      = req_q;
    flags_o.in_acc   = in_acc;
    flags_o.out_free = out_free;
    flags_o.full     = (sp_q == SPW'(STACK_DEPTH));
    flags_o.few      = (sp_q < SPW'(2));
    flags_o.bzero    = (top_q == '0);
    flags_o.sp0      = (sp_q == '0);
    flags_o.sp1      = (sp_q == SPW'(1));
    flags_o.div_busy = (cnt_q != '0);
  end

  assign out_valid_o  = ov_q;
  assign out_status_o = os_q;
  assign out_value_o  = ov_val_q;
  assign out_depth_o  = od_q;

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer above depth");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> ov_q)
    else $error("result transaction lost");

  a_eol_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ctrl_i.clr_sp) |=> (sp_q == '0))
    else $error("end of line did not clear stack");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.uop == rpn_pkg::UOP_DIV_STEP) |-> (rem_q < dvs_q))
    else $error("divider remainder out of range");
`endif

endmodule

// File: rtl/rpn_stack_evaluator_unit.sv
// RPN evaluator: one token per input transaction (tuser = token kind, tdata = Q16.16
// operand for push), one output transaction per token carrying status in tuser and
// {stack depth, value} in tdata. Control runs from a microcode ROM over a small
// datapath; tokens are handled one at a time, and divide is bound by the radix-2
// restoring divider, which works through the 32+FRAC_BITS-bit dividend (48 bits at
// Q16.16). The output register lets the next token be taken while a result waits.
// The operand stack is a RAM holding all but the top entry, which sits in a register.
module rpn_stack_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = 128,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] number_value
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] result_value, [39:32] stack_depth
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  rpn_pkg::ctrl_t  ctrl;
  rpn_pkg::flags_t flags;
  logic [rpn_pkg::DataW-1:0]  out_value;
  logic [rpn_pkg::DepthW-1:0] out_depth;

  rpn_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .flags_o      (flags),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_req_i     (s_axis_tuser_i),
    .in_num_i     (s_axis_tdata_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_value_o  (out_value),
    .out_depth_o  (out_depth)
  );

  assign m_axis_tdata_o = {out_depth, out_value};

endmodule

// File: verif/rpn_stack_checker.sv
module rpn_stack_checker #(
  parameter int unsigned STACK_DEPTH = 128,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_tvalid_i,
  input  logic        in_tready_i,
  input  logic [31:0] in_tdata_i,   // [31:0] number_value
  input  logic [2:0]  in_tuser_i,   // [2:0] req_type
  input  logic        out_tvalid_i,
  input  logic        out_tready_i,
  input  logic [39:0] out_tdata_i,  // [31:0] result_value, [39:32] stack_depth
  input  logic [2:0]  out_tuser_i,  // [2:0] status
  output int          fail_count_o,
  output int          pending_o,
  output int          tokens_o,
  output int          results_o,
  output logic [7:0]  status_seen_o,
  output int          deepest_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    rpn_pkg::st_e                      status;
    logic [rpn_pkg::DataW-1:0]         value;
    logic [rpn_pkg::DepthW-1:0]        depth;
  } token_result_t;

  logic [rpn_pkg::DataW-1:0] operands [STACK_DEPTH];
  int unsigned               operand_count = 0;
  token_result_t             awaited_results [$];

  initial begin
    fail_count_o  = 0;
    pending_o     = 0;
    tokens_o      = 0;
    results_o     = 0;
    status_seen_o = '0;
    deepest_o     = 0;
  end

  function automatic logic [63:0] magnitude(logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [rpn_pkg::DataW-1:0] saturate(logic neg, logic [63:0] mag);
    if (neg) begin
      return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
    end
    return (mag > 64'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
  endfunction

  function automatic logic [rpn_pkg::DataW-1:0] top_of_stack();
    return (operand_count == 0) ? '0 : operands[operand_count-1];
  endfunction

  // b is the top entry, a the one beneath it
  function automatic token_result_t evaluate_token(logic [rpn_pkg::ReqW-1:0] req,
                                                   logic [rpn_pkg::DataW-1:0] num);
    token_result_t    r;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] sum;
    r.status = rpn_pkg::ST_OK;
    r.value  = '0;
    case (req)
      rpn_pkg::REQ_PUSH: begin
        if (operand_count < STACK_DEPTH) begin
          operands[operand_count] = num;
          operand_count++;
        end else begin
          r.status = rpn_pkg::ST_FULL;
        end
        r.value = top_of_stack();
      end
      rpn_pkg::REQ_ADD, rpn_pkg::REQ_SUB, rpn_pkg::REQ_MUL, rpn_pkg::REQ_DIV: begin
        if (operand_count < 2) begin
          r.status = rpn_pkg::ST_FEW;
        end else begin
          b = {{32{operands[operand_count-1][31]}}, operands[operand_count-1]};
          a = {{32{operands[operand_count-2][31]}}, operands[operand_count-2]};
          operand_count--;
          case (req)
            rpn_pkg::REQ_ADD: begin
              sum = a + b;
              operands[operand_count-1] = saturate(sum[63], magnitude(sum));
            end
            rpn_pkg::REQ_SUB: begin
              sum = a - b;
              operands[operand_count-1] = saturate(sum[63], magnitude(sum));
            end
            rpn_pkg::REQ_MUL: begin
              operands[operand_count-1] =
                saturate(a[63] ^ b[63], (magnitude(a) * magnitude(b)) >> FRAC_BITS);
            end
            default: begin
              if (b == 0) begin
                r.status = rpn_pkg::ST_DIVZ;
              end else begin
                operands[operand_count-1] =
                  saturate(a[63] ^ b[63], (magnitude(a) << FRAC_BITS) / magnitude(b));
              end
            end
          endcase
        end
        r.value = top_of_stack();
      end
      rpn_pkg::REQ_EOL: begin
        if (operand_count == 1) begin
          r.status = rpn_pkg::ST_RESULT;
          r.value  = operands[0];
        end else if (operand_count == 0) begin
          r.status = rpn_pkg::ST_EMPTY;
        end else begin
          r.status = rpn_pkg::ST_MANY;
        end
        operand_count = 0;
      end
      default: begin
        r.status = rpn_pkg::ST_INVALID;
        r.value  = top_of_stack();
      end
    endcase
    r.depth = rpn_pkg::DepthW'(operand_count);
    return r;
  endfunction

  always @(posedge clk_i) begin
    token_result_t want;
    token_result_t got;
    if (rst_ni) begin
      if (in_tvalid_i && in_tready_i) begin
        awaited_results.push_back(evaluate_token(in_tuser_i, in_tdata_i));
        tokens_o++;
        if (operand_count > deepest_o) begin
          deepest_o = operand_count;
        end
      end
      if (out_tvalid_i && out_tready_i) begin
        got.status = rpn_pkg::st_e'(out_tuser_i);
        got.value  = out_tdata_i[31:0];
        got.depth  = out_tdata_i[39:32];
        results_o++;
        status_seen_o[out_tuser_i] = 1'b1;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result status %0d value %h depth %0d", $time,
                   got.status, got.value, got.depth);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_count_o++;
          end
          if (got.value !== want.value) begin
            $display("%0t: value expected %h actual %h", $time, want.value, got.value);
            fail_count_o++;
          end
          if (got.depth !== want.depth) begin
            $display("%0t: depth expected %0d actual %0d", $time, want.depth, got.depth);
            fail_count_o++;
          end
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// File: verif/tb_rpn_stack_evaluator_unit.sv
module tb_rpn_stack_evaluator_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH  = 128;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int          TOKEN_TARGET = 950;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 100;
  localparam int          CYCLE_LIMIT  = 600000;

  localparam logic [rpn_pkg::ReqW-1:0] REQ_UNUSED = 3'd7;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata  = '0;
  logic [2:0]  in_tuser  = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;

  int          fail_count;
  int          pending_count;
  int          token_count;
  int          results_count;
  logic [7:0]  status_seen;
  int          deepest;

  int          items_sent = 0;
  logic        burst      = 1'b0;
  logic        sink_hold  = 1'b0;
  logic        fill_done  = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rpn_stack_evaluator_unit #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(in_tvalid),
    .s_axis_tready_o(in_tready),
    .s_axis_tdata_i (in_tdata),
    .s_axis_tuser_i (in_tuser),
    .m_axis_tvalid_o(out_tvalid),
    .m_axis_tready_i(out_tready),
    .m_axis_tdata_o (out_tdata),
    .m_axis_tuser_o (out_tuser)
  );

  rpn_stack_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_tvalid_i  (in_tvalid),
    .in_tready_i  (in_tready),
    .in_tdata_i   (in_tdata),
    .in_tuser_i   (in_tuser),
    .out_tvalid_i (out_tvalid),
    .out_tready_i (out_tready),
    .out_tdata_i  (out_tdata),
    .out_tuser_i  (out_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_count),
    .tokens_o     (token_count),
    .results_o    (results_count),
    .status_seen_o(status_seen),
    .deepest_o    (deepest)
  );

  // mostly back to back, sometimes a short gap, rarely a long gap
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] random_operand();
    int r;
    int k;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: begin
        k = $urandom_range(0, 5);
        case (k)
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0001_0000;
          3: return 32'hffff_0000;
          4: return 32'h0000_0001;
          default: return 32'hffff_ffff;
        endcase
      end
      2, 3, 4, 5: return {16'($signed($urandom_range(0, 16)) - 8), 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  task automatic send_token(input logic [rpn_pkg::ReqW-1:0] req, input logic [31:0] num);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= num;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    gap = burst ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    wait (results_count == items_sent);
  endtask

  function automatic logic [rpn_pkg::ReqW-1:0] random_operator();
    return rpn_pkg::ReqW'($urandom_range(int'(rpn_pkg::REQ_ADD), int'(rpn_pkg::REQ_DIV)));
  endfunction

  // complete = 0 leaves operands behind before the end of line
  task automatic send_expression(input int n_operands, input bit complete);
    int depth;
    int pushed;
    depth  = 0;
    pushed = 0;
    while (pushed < n_operands || (complete && depth > 1)) begin
      if (pushed < n_operands && (depth < 2 || $urandom_range(0, 2) != 0)) begin
        send_token(rpn_pkg::REQ_PUSH, random_operand());
        depth++;
        pushed++;
      end else begin
        send_token(random_operator(), $urandom());
        depth--;
      end
    end
    send_token(rpn_pkg::REQ_EOL, $urandom());
  endtask

  // stall the sink, overflow the stack, then drain completely
  task automatic fill_past_full();
    send_token(rpn_pkg::REQ_EOL, '0);
    sink_hold = 1'b1;
    repeat (STACK_DEPTH + 4) send_token(rpn_pkg::REQ_PUSH, random_operand());
    repeat (8) send_token(random_operator(), $urandom());
    repeat (10) send_token(rpn_pkg::REQ_PUSH, random_operand());
    send_token(rpn_pkg::REQ_EOL, '0);
    wait_all_results();
  endtask

  initial begin : sink
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (sink_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
      end else if (burst || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (idle_len() + 1) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
    $display("tb_rpn_stack_evaluator_unit failed");
    $finish;
  end

  initial begin : stimulus
    int pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_token(rpn_pkg::REQ_EOL, '1);
    send_token(rpn_pkg::REQ_ADD, '0);
    send_token(rpn_pkg::REQ_PUSH, 32'h7fff_ffff);
    send_token(rpn_pkg::REQ_DIV, '1);
    send_token(rpn_pkg::REQ_PUSH, 32'h0000_0001);
    send_token(rpn_pkg::REQ_ADD, '0);
    send_token(rpn_pkg::REQ_PUSH, 32'h8000_0000);
    send_token(rpn_pkg::REQ_SUB, '0);
    send_token(rpn_pkg::REQ_PUSH, 32'h8000_0000);
    send_token(rpn_pkg::REQ_MUL, '0);
    send_token(rpn_pkg::REQ_PUSH, 32'h0000_0000);
    send_token(rpn_pkg::REQ_DIV, '0);
    send_token(rpn_pkg::REQ_PUSH, 32'hffff_0000);
    send_token(rpn_pkg::REQ_DIV, '0);
    send_token(rpn_pkg::REQ_PUSH, 32'hfffe_8000);
    send_token(rpn_pkg::REQ_MUL, '1);
    send_token(rpn_pkg::REQ_PUSH, 32'h0003_0000);
    send_token(rpn_pkg::REQ_DIV, '0);
    send_token(rpn_pkg::REQ_INVALID, '1);
    send_token(REQ_UNUSED, '0);
    send_token(rpn_pkg::REQ_EOL, '0);
    send_token(rpn_pkg::REQ_PUSH, 32'h0001_8000);
    send_token(rpn_pkg::REQ_PUSH, 32'hffff_ffff);
    send_token(rpn_pkg::REQ_EOL, '0);

    while (items_sent < TOKEN_TARGET) begin
      burst = ($urandom_range(0, 7) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 75) begin
        send_expression($urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 6), 1'b1);
      end else if (pick < 88) begin
        send_token(rpn_pkg::ReqW'($urandom_range(0, 7)), random_operand());
      end else begin
        send_expression($urandom_range(0, 5), 1'b0);
      end
      if (!fill_done && items_sent > 400) begin
        burst = 1'b0;
        fill_past_full();
        fill_done = 1'b1;
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d tokens, %0d results, deepest stack %0d, status codes seen %b",
             token_count, results_count, deepest, status_seen);
    $display("directed edge cases, random expressions, noise, a stack overflow under stall");
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_rpn_stack_evaluator_unit passed");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending_count);
      $display("tb_rpn_stack_evaluator_unit failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_seq.sv
rtl/rpn_dp.sv
rtl/rpn_stack_evaluator_unit.sv
verif/rpn_stack_checker.sv
verif/tb_rpn_stack_evaluator_unit.sv
